// ===== sv/assert_macros.svh =====
// Assertion macros shared by the trig approximation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BTRIG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define BTRIG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/btrig_pkg.sv =====
// Package with the types, formats and constants of the trig approximation block.
package btrig_pkg;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 16;
    localparam int INNER_FRAC_BITS  = 30;

    // Function select codes.
    localparam logic [1:0] FUNC_COS     = 2'd0;
    localparam logic [1:0] FUNC_SIN     = 2'd1;
    localparam logic [1:0] FUNC_TAN     = 2'd2;
    localparam logic [1:0] FUNC_TAN_ALT = 2'd3;

    // Angle work width, folded angle width and numerator/denominator width.
    localparam int AW = ANGLE_FRAC_BITS + 4;
    localparam int XW = ANGLE_FRAC_BITS + 1;
    localparam int NW = 2 * ANGLE_FRAC_BITS + 5;
    // Magnitude of cosine and sine with one integer bit.
    localparam int MW = INNER_FRAC_BITS + 1;
    localparam int MW1 = MW + 1;
    localparam int RS = INNER_FRAC_BITS - RESULT_FRAC_BITS;

    // Divider cell widths, wide enough for every row of cells.
    localparam int DIV_W = (NW > 32) ? NW : 32;
    localparam int DVD_W = RESULT_FRAC_BITS + 32;
    localparam int QW    = DVD_W;

    // Number of cells in each row.
    localparam int NRED  = 32;
    localparam int NLANE = MW;
    localparam int NTAN  = DVD_W;

    localparam logic [63:0] PI60 = 64'h3243F6A8885A308D;

    localparam logic [63:0] HALF64 =
        ((PI60 >> 1) + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] PI64 =
        (PI60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] THREE64 =
        (((PI60 * 64'd3) >> 1) + (64'd1 << (59 - ANGLE_FRAC_BITS)))
        >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] TWO64 =
        ((PI60 << 1) + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] P30_64 = (PI60 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] SQ64 = P30_64 * P30_64;
    localparam logic [63:0] PSQ64 =
        (SQ64 + (64'd1 << (59 - 2 * ANGLE_FRAC_BITS))) >> (60 - 2 * ANGLE_FRAC_BITS);
    // Residue of the offset that turns the signed angle into an unsigned one.
    localparam logic [63:0] C0_64 = (64'd1 << 31) % TWO64;

    localparam logic [AW-1:0] HALF_A  = AW'(HALF64);
    localparam logic [AW-1:0] PI_A    = AW'(PI64);
    localparam logic [AW-1:0] THREE_A = AW'(THREE64);
    localparam logic [AW-1:0] TWO_A   = AW'(TWO64);
    localparam logic [AW-1:0] C0_A    = AW'(C0_64);
    localparam logic [NW-1:0] PSQ_N   = NW'(PSQ64);

    localparam logic [QW-1:0] QMAX_POS = QW'(32'h7FFFFFFF);
    localparam logic [QW-1:0] QMAX_NEG = QW'(32'h80000000);

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] angle;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
    } res_t;

    // State handed from one shift-subtract cell to the next.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [DVD_W-1:0] dvd;
        logic [QW-1:0]    quo;
        logic [1:0]       func;
        logic             neg;
        logic             aux;
        logic             zero;
        logic [31:0]      side_val;
    } dcell_t;

endpackage

// ===== sv/btrig_cell.sv =====
// One shift-subtract cell: shifts in a dividend bit and develops one quotient bit.
module btrig_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  btrig_pkg::dcell_t in_cell,
    output logic              out_valid,
    output btrig_pkg::dcell_t out_cell
);

    logic [btrig_pkg::DIV_W-1:0] trial;
    logic [btrig_pkg::DIV_W-1:0] diff;
    logic                        take;
    btrig_pkg::dcell_t           cell_next;
    btrig_pkg::dcell_t           cell_reg;
    logic                        valid_reg;

    always_comb
    begin
        trial = {in_cell.rem[btrig_pkg::DIV_W-2:0], in_cell.dvd[btrig_pkg::DVD_W-1]};
        diff  = trial - in_cell.den;
        take  = (trial >= in_cell.den);
        cell_next      = in_cell;
        cell_next.rem  = take ? diff : trial;
        cell_next.dvd  = {in_cell.dvd[btrig_pkg::DVD_W-2:0], 1'b0};
        cell_next.quo  = {in_cell.quo[btrig_pkg::QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== sv/btrig_front.sv =====
// Offset removal, sine shift, quadrant fold, squaring and Bhaskara num/den setup.
module btrig_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  btrig_pkg::dcell_t in_cell,
    output logic              out_valid,
    output btrig_pkg::dcell_t cos_cell,
    output btrig_pkg::dcell_t sin_cell
);

    localparam int AW = btrig_pkg::AW;
    localparam int XW = btrig_pkg::XW;
    localparam int NW = btrig_pkg::NW;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [1:0]    s1_func_reg, s2_func_reg, s3_func_reg, s4_func_reg;
    logic [AW-1:0] s1_r_reg;
    logic [AW-1:0] s2_rc_reg, s2_rs_reg;
    logic [XW-1:0] s3_xc_reg, s3_xs_reg;
    logic          s3_negc_reg, s3_negs_reg, s4_negc_reg, s4_negs_reg;
    logic [2*XW-1:0] s4_sqc_reg, s4_sqs_reg;
    btrig_pkg::dcell_t s5_cos_reg, s5_sin_reg;

    logic [AW-1:0] r1, r_next, t2, rs_next;
    logic [XW:0]   fold_c, fold_s;
    btrig_pkg::dcell_t cos_next, sin_next;

    // Folds an angle in [0, 2pi) onto [0, pi/2]; the top bit is the sign.
    function automatic logic [XW:0] fold(input logic [AW-1:0] r);
        logic [AW-1:0] x;
        logic          neg;
        if (r < btrig_pkg::HALF_A)
        begin
            x = r;
            neg = 1'b0;
        end
        else if (r < btrig_pkg::PI_A)
        begin
            x = btrig_pkg::PI_A - r;
            neg = 1'b1;
        end
        else if (r < btrig_pkg::THREE_A)
        begin
            x = r - btrig_pkg::PI_A;
            neg = 1'b1;
        end
        else
        begin
            x = btrig_pkg::TWO_A - r;
            neg = 1'b0;
        end
        return {neg, x[XW-1:0]};
    endfunction

    function automatic btrig_pkg::dcell_t lane_init(input logic [2*XW-1:0] sq,
                                                    input logic neg_in,
                                                    input logic [1:0] func);
        logic [NW-1:0] num;
        logic [NW-1:0] den;
        logic [NW-1:0] mag;
        btrig_pkg::dcell_t c;
        num = btrig_pkg::PSQ_N - (NW'(sq) << 2);
        den = btrig_pkg::PSQ_N + NW'(sq);
        mag = num[NW-1] ? (NW'(0) - num) : num;
        c = '0;
        c.rem  = btrig_pkg::DIV_W'(mag >> 1);
        c.den  = btrig_pkg::DIV_W'(den);
        c.dvd  = btrig_pkg::DVD_W'(mag[0]) << (btrig_pkg::DVD_W - 1);
        c.func = func;
        c.neg  = neg_in ^ num[NW-1];
        return c;
    endfunction

    always_comb
    begin
        r1      = in_cell.rem[AW-1:0] - btrig_pkg::C0_A;
        r_next  = r1[AW-1] ? (r1 + btrig_pkg::TWO_A) : r1;
        t2      = s1_r_reg - btrig_pkg::HALF_A;
        rs_next = t2[AW-1] ? (t2 + btrig_pkg::TWO_A) : t2;
        fold_c  = fold(s2_rc_reg);
        fold_s  = fold(s2_rs_reg);
        cos_next = lane_init(s4_sqc_reg, s4_negc_reg, s4_func_reg);
        sin_next = lane_init(s4_sqs_reg, s4_negs_reg, s4_func_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_func_reg <= in_cell.func;
            s1_r_reg    <= r_next;
            s2_func_reg <= s1_func_reg;
            s2_rc_reg   <= s1_r_reg;
            s2_rs_reg   <= rs_next;
            s3_func_reg <= s2_func_reg;
            s3_xc_reg   <= fold_c[XW-1:0];
            s3_negc_reg <= fold_c[XW];
            s3_xs_reg   <= fold_s[XW-1:0];
            s3_negs_reg <= fold_s[XW];
            s4_func_reg <= s3_func_reg;
            s4_sqc_reg  <= s3_xc_reg * s3_xc_reg;
            s4_sqs_reg  <= s3_xs_reg * s3_xs_reg;
            s4_negc_reg <= s3_negc_reg;
            s4_negs_reg <= s3_negs_reg;
            s5_cos_reg  <= cos_next;
            s5_sin_reg  <= sin_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign cos_cell  = s5_cos_reg;
    assign sin_cell  = s5_sin_reg;

endmodule

// ===== sv/btrig_round.sv =====
// Rounds both quotients, forms the cosine or sine result and sets up the tangent division.
module btrig_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              cos_valid,
    input  logic              sin_valid,
    input  btrig_pkg::dcell_t cos_cell,
    input  btrig_pkg::dcell_t sin_cell,
    output logic              out_valid,
    output btrig_pkg::dcell_t out_cell
);

    localparam int MW  = btrig_pkg::MW;
    localparam int MW1 = btrig_pkg::MW1;

    logic [MW-1:0]  mag_c, mag_s, mag_sel;
    logic           neg_c, neg_s, neg_sel;
    logic [MW1-1:0] rsum;
    logic [31:0]    m32;
    btrig_pkg::dcell_t cell_next;
    btrig_pkg::dcell_t cell_reg;
    logic           valid_reg;

    // Rounds half up on the final remainder.
    function automatic logic [MW-1:0] round_mag(input btrig_pkg::dcell_t c);
        logic up;
        up = ({c.rem, 1'b0} >= {1'b0, c.den});
        return c.quo[MW-1:0] + MW'(up);
    endfunction

    always_comb
    begin
        mag_c = round_mag(cos_cell);
        mag_s = round_mag(sin_cell);
        neg_c = cos_cell.neg && (mag_c != '0);
        neg_s = sin_cell.neg && (mag_s != '0);
        mag_sel = (cos_cell.func == btrig_pkg::FUNC_SIN) ? mag_s : mag_c;
        neg_sel = (cos_cell.func == btrig_pkg::FUNC_SIN) ? neg_s : neg_c;
        rsum = {1'b0, mag_sel} + (MW1'(1) << (btrig_pkg::RS - 1));
        m32  = 32'(rsum >> btrig_pkg::RS);

        cell_next          = '0;
        cell_next.den      = btrig_pkg::DIV_W'(mag_c);
        cell_next.dvd      = (btrig_pkg::DVD_W'(mag_s) << btrig_pkg::RESULT_FRAC_BITS)
                             + btrig_pkg::DVD_W'(mag_c >> 1);
        cell_next.func     = cos_cell.func;
        cell_next.neg      = neg_s ^ neg_c;
        cell_next.aux      = neg_s;
        cell_next.zero     = (mag_c == '0);
        cell_next.side_val = neg_sel ? (32'd0 - m32) : m32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= cos_valid && sin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ===== sv/bhaskara_trig_approx.sv =====
// Top level of the Bhaskara I cosine, sine and tangent approximation pipeline.
// Takes one request per clock while req_stall is low and returns one result per
// request, in order. The pipeline has three rows of shift-subtract cells: 32 for
// the reduction modulo 2*pi, 31 for the Bhaskara quotients of cosine and sine (run
// side by side), and RESULT_FRAC_BITS + 32 for the tangent quotient, plus five fold
// and multiply stages, a rounding stage and the output register. A skid register
// behind the output lets the pipeline finish one more result while the output waits.
module bhaskara_trig_approx (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  btrig_pkg::req_t req_data,
    output logic            res_valid,
    input  logic            res_stall,
    output btrig_pkg::res_t res_data
);

    `include "assert_macros.svh"

    localparam int NRED  = btrig_pkg::NRED;
    localparam int NLANE = btrig_pkg::NLANE;
    localparam int NTAN  = btrig_pkg::NTAN;

    logic adv;

    btrig_pkg::dcell_t red_c [NRED+1];
    logic              red_v [NRED+1];
    btrig_pkg::dcell_t cos_c [NLANE+1];
    logic              cos_v [NLANE+1];
    btrig_pkg::dcell_t sin_c [NLANE+1];
    logic              sin_v [NLANE+1];
    btrig_pkg::dcell_t tan_c [NTAN+1];
    logic              tan_v [NTAN+1];

    logic              front_valid;
    btrig_pkg::dcell_t tcell;
    logic              pipe_valid;
    btrig_pkg::res_t   fin;
    logic [btrig_pkg::QW-1:0] qc;

    logic              out_valid_reg, skid_full_reg;
    btrig_pkg::res_t   out_reg, skid_reg;

    assign adv = !skid_full_reg;

    // The signed angle is offset by 2^31 so the reduction divides an unsigned word.
    always_comb
    begin
        red_c[0]      = '0;
        red_c[0].den  = btrig_pkg::DIV_W'(btrig_pkg::TWO_A);
        red_c[0].dvd  = btrig_pkg::DVD_W'(req_data.angle ^ 32'h80000000)
                        << (btrig_pkg::DVD_W - 32);
        red_c[0].func = req_data.func;
        red_v[0]      = req_valid;
    end

    for (genvar i = 0; i < NRED; i++)
    begin : g_red
        btrig_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (red_v[i]),
            .in_cell   (red_c[i]),
            .out_valid (red_v[i+1]),
            .out_cell  (red_c[i+1])
        );
    end

    btrig_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (red_v[NRED]),
        .in_cell   (red_c[NRED]),
        .out_valid (front_valid),
        .cos_cell  (cos_c[0]),
        .sin_cell  (sin_c[0])
    );

    assign cos_v[0] = front_valid;
    assign sin_v[0] = front_valid;

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        btrig_cell u_cos (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cos_v[i]),
            .in_cell   (cos_c[i]),
            .out_valid (cos_v[i+1]),
            .out_cell  (cos_c[i+1])
        );
        btrig_cell u_sin (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sin_v[i]),
            .in_cell   (sin_c[i]),
            .out_valid (sin_v[i+1]),
            .out_cell  (sin_c[i+1])
        );
    end

    btrig_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cos_valid (cos_v[NLANE]),
        .sin_valid (sin_v[NLANE]),
        .cos_cell  (cos_c[NLANE]),
        .sin_cell  (sin_c[NLANE]),
        .out_valid (tan_v[0]),
        .out_cell  (tan_c[0])
    );

    for (genvar i = 0; i < NTAN; i++)
    begin : g_tan
        btrig_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (tan_v[i]),
            .in_cell   (tan_c[i]),
            .out_valid (tan_v[i+1]),
            .out_cell  (tan_c[i+1])
        );
    end

    assign tcell      = tan_c[NTAN];
    assign pipe_valid = tan_v[NTAN];

    // Tangent clamps to the 32-bit limits; a zero cosine takes the sign of the sine.
    always_comb
    begin
        qc            = tcell.quo;
        fin.value     = tcell.side_val;
        fin.saturated = 1'b0;
        if (tcell.func == btrig_pkg::FUNC_TAN || tcell.func == btrig_pkg::FUNC_TAN_ALT)
        begin
            if (tcell.zero)
            begin
                fin.saturated = 1'b1;
                fin.value     = tcell.aux ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else
            begin
                if (!tcell.neg && (tcell.quo > btrig_pkg::QMAX_POS))
                begin
                    fin.saturated = 1'b1;
                    qc = btrig_pkg::QMAX_POS;
                end
                if (tcell.neg && (tcell.quo > btrig_pkg::QMAX_NEG))
                begin
                    fin.saturated = 1'b1;
                    qc = btrig_pkg::QMAX_NEG;
                end
                fin.value = tcell.neg ? (32'd0 - qc[31:0]) : qc[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_valid_reg && res_stall)
        begin
            if (pipe_valid && adv)
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            out_valid_reg <= 1'b1;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && res_stall)
        begin
            if (!skid_full_reg)
            begin
                skid_reg <= fin;
            end
        end
        else if (skid_full_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= fin;
        end
    end

    assign req_stall = skid_full_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    `BTRIG_ASSERT_IMP(a_skid_behind_out, skid_full_reg, res_valid, "skid holds data with empty output")
    `BTRIG_ASSERT(a_skid_fill, $rose(skid_full_reg) |-> $past(res_valid && res_stall), "skid filled without stall")
    `BTRIG_ASSERT(a_result_lands, pipe_valid && !skid_full_reg && !(res_valid && res_stall) |=> res_valid, "result lost")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the Bhaskara I cosine, sine and tangent pipeline.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 900;
    localparam int SETTLE     = 200;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        btrig_pkg::req_t req;
        bit              typed;      // expected result written into the table
        btrig_pkg::res_t res;
        int              phase;      // idle pattern in force while this request is offered
        bit              drain;      // hold this request until nothing is outstanding
    } stim_t;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    btrig_pkg::req_t req_data;
    logic            res_valid;
    logic            res_stall;
    btrig_pkg::res_t res_data;

    stim_t           stim_q[$];
    btrig_pkg::res_t pending_q[$];
    int              next_idx;
    int              errors;
    int              quiet_cycles;

    bhaskara_trig_approx u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rounds a constant held with 60 fraction bits to the angle format.
    function automatic longint angle_const(bit [63:0] c60);
        return longint'((c60 + (64'd1 << (59 - btrig_pkg::ANGLE_FRAC_BITS)))
                        >> (60 - btrig_pkg::ANGLE_FRAC_BITS));
    endfunction

    function automatic longint pi_squared();
        bit [63:0] p30;
        bit [63:0] sq;
        p30 = (btrig_pkg::PI60 + (64'd1 << 29)) >> 30;
        sq  = p30 * p30;
        return longint'((sq + (64'd1 << (59 - 2 * btrig_pkg::ANGLE_FRAC_BITS)))
                        >> (60 - 2 * btrig_pkg::ANGLE_FRAC_BITS));
    endfunction

    // Quotient magnitude with 30 fraction bits, rounded half up.
    function automatic bit [63:0] quotient30(bit [63:0] num, bit [63:0] den);
        bit [63:0] q;
        bit [63:0] rem;
        q   = 0;
        rem = num;
        if (rem >= den)
        begin
            q   = 1;
            rem = rem - den;
        end
        for (int i = 0; i < btrig_pkg::INNER_FRAC_BITS; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den)
            begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        if (2 * rem >= den)
            q = q + 1;
        return q;
    endfunction

    function automatic longint bhaskara_cos30(longint a);
        longint half;
        longint pi_a;
        longint three_half;
        longint two_pi;
        longint psq;
        longint r;
        longint x;
        longint num;
        longint den;
        bit     neg;
        bit [63:0] mag;
        half       = angle_const(btrig_pkg::PI60 >> 1);
        pi_a       = angle_const(btrig_pkg::PI60);
        three_half = angle_const((btrig_pkg::PI60 * 64'd3) >> 1);
        two_pi     = angle_const(btrig_pkg::PI60 << 1);
        psq        = pi_squared();
        neg        = 1'b0;
        r = a % two_pi;
        if (r < 0)
            r = r + two_pi;
        if (r < half)
            x = r;
        else if (r < pi_a)
        begin
            x   = pi_a - r;
            neg = 1'b1;
        end
        else if (r < three_half)
        begin
            x   = r - pi_a;
            neg = 1'b1;
        end
        else
            x = two_pi - r;
        num = psq - 4 * x * x;
        den = psq + x * x;
        if (num < 0)
        begin
            neg = !neg;
            mag = quotient30(64'(-num), 64'(den));
        end
        else
            mag = quotient30(64'(num), 64'(den));
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic btrig_pkg::res_t trig_predict(btrig_pkg::req_t rq);
        btrig_pkg::res_t res;
        longint a;
        longint half;
        longint s;
        longint c;
        bit     neg;
        bit [63:0] ms;
        bit [63:0] mc;
        bit [63:0] q;
        a    = longint'(rq.angle);
        half = angle_const(btrig_pkg::PI60 >> 1);
        res.saturated = 1'b0;
        if (rq.func[1])
        begin
            s   = bhaskara_cos30(a - half);
            c   = bhaskara_cos30(a);
            neg = (s < 0) != (c < 0);
            ms  = 64'(s < 0 ? -s : s);
            mc  = 64'(c < 0 ? -c : c);
            if (mc == 0)
            begin
                res.saturated = 1'b1;
                res.value     = (s < 0) ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else
            begin
                q = ((ms << btrig_pkg::RESULT_FRAC_BITS) + (mc >> 1)) / mc;
                if (!neg && q > 64'h7FFFFFFF)
                begin
                    res.saturated = 1'b1;
                    q = 64'h7FFFFFFF;
                end
                if (neg && q > 64'h80000000)
                begin
                    res.saturated = 1'b1;
                    q = 64'h80000000;
                end
                res.value = neg ? 32'(64'd0 - q) : q[31:0];
            end
        end
        else
        begin
            c  = bhaskara_cos30(rq.func == btrig_pkg::FUNC_SIN ? a - half : a);
            ms = 64'(c < 0 ? -c : c);
            ms = (ms + (64'd1 << (btrig_pkg::RS - 1))) >> btrig_pkg::RS;
            res.value = (c < 0) ? 32'(64'd0 - ms) : ms[31:0];
        end
        return res;
    endfunction

    function automatic stim_t make_row(logic [1:0] f, logic [31:0] ang, bit typed,
                                       logic [31:0] val, logic sat);
        stim_t row;
        row.req.func  = f;
        row.req.angle = ang;
        row.typed     = typed;
        row.res.value = val;
        row.res.saturated = sat;
        row.phase     = 0;
        row.drain     = 1'b0;
        return row;
    endfunction

    // Random angle, mostly close to a multiple of pi/2 where the folds and the
    // tangent clamp sit.
    function automatic logic [31:0] random_angle();
        longint k;
        longint a;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        k = longint'($urandom_range(0, 160)) - 80;
        a = k * longint'(btrig_pkg::HALF_A) + longint'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 2) == 0)
            a = a + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        if (a > 64'sh7FFFFFFF)
            a = 64'sh7FFFFFFF;
        if (a < -64'sh80000000)
            a = -64'sh80000000;
        return a[31:0];
    endfunction

    function automatic int send_idle(int phase);
        return phase == 1 ? 31 : (phase == 2 ? 86 : 0);
    endfunction

    function automatic int recv_idle(int phase);
        return phase == 1 ? 86 : (phase == 2 ? 31 : 0);
    endfunction

    // Request side and result side share one block, so the queue of pending
    // results is updated in a fixed order within each cycle.
    always @(posedge clk or negedge rst_n)
    begin
        int              phase;
        btrig_pkg::res_t want;
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            req_data     <= '0;
            res_stall    <= 1'b0;
            next_idx     = 0;
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (req_valid && !req_stall)
            begin
                quiet_cycles = 0;
                if (stim_q[next_idx].typed)
                    pending_q.push_back(stim_q[next_idx].res);
                else
                    pending_q.push_back(trig_predict(stim_q[next_idx].req));
                next_idx = next_idx + 1;
            end
            if (res_valid && !res_stall)
            begin
                quiet_cycles = 0;
                if (pending_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result value=%h saturated=%b",
                             $realtime, res_data.value, res_data.saturated);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (res_data.value !== want.value)
                    begin
                        errors++;
                        $display("%0t: value expected %h actual %h", $realtime,
                                 want.value, res_data.value);
                    end
                    if (res_data.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $realtime,
                                 want.saturated, res_data.saturated);
                    end
                end
            end
            phase = (next_idx < stim_q.size()) ? stim_q[next_idx].phase : 0;
            if (!req_valid || !req_stall)
            begin
                if (next_idx < stim_q.size()
                    && !(stim_q[next_idx].drain && pending_q.size() != 0)
                    && $urandom_range(0, 99) >= send_idle(phase))
                begin
                    req_valid <= 1'b1;
                    req_data  <= stim_q[next_idx].req;
                end
                else
                    req_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(0, 99) < recv_idle(phase));
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("bhaskara_trig_approx verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        stim_t row;
        errors = 0;
        // Cosine of zero is exactly one.
        stim_q.push_back(make_row(btrig_pkg::FUNC_COS, 32'h0, 1'b1, 32'h00010000, 1'b0));
        stim_q.push_back(make_row(btrig_pkg::FUNC_SIN, 32'h0, 1'b0, '0, 1'b0));
        stim_q.push_back(make_row(btrig_pkg::FUNC_TAN, 32'h0, 1'b0, '0, 1'b0));
        stim_q.push_back(make_row(btrig_pkg::FUNC_TAN_ALT, 32'h0, 1'b0, '0, 1'b0));
        for (int f = 0; f < 4; f++)
        begin
            stim_q.push_back(make_row(f[1:0], 32'h7FFFFFFF, 1'b0, '0, 1'b0));
            stim_q.push_back(make_row(f[1:0], 32'h80000000, 1'b0, '0, 1'b0));
            stim_q.push_back(make_row(f[1:0], 32'(btrig_pkg::HALF_A), 1'b0, '0, 1'b0));
        end
        // Tangent around the quarter turns, where the cosine vanishes or the
        // quotient runs out of range.
        for (int d = -1; d <= 1; d++)
        begin
            stim_q.push_back(make_row(btrig_pkg::FUNC_TAN,
                                      32'(int'(btrig_pkg::HALF_A) + d), 1'b0, '0, 1'b0));
            stim_q.push_back(make_row(btrig_pkg::FUNC_TAN,
                                      32'(int'(btrig_pkg::THREE_A) + d), 1'b0, '0, 1'b0));
            stim_q.push_back(make_row(btrig_pkg::FUNC_TAN,
                                      32'(-int'(btrig_pkg::HALF_A) + d), 1'b0, '0, 1'b0));
        end
        stim_q.push_back(make_row(btrig_pkg::FUNC_COS, 32'(btrig_pkg::PI_A), 1'b0, '0, 1'b0));
        stim_q.push_back(make_row(btrig_pkg::FUNC_SIN, 32'(btrig_pkg::TWO_A), 1'b0, '0, 1'b0));
        stim_q.push_back(make_row(btrig_pkg::FUNC_TAN, 32'hFFFFFFFF, 1'b0, '0, 1'b0));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            row = make_row(2'($urandom_range(0, 3)), random_angle(), 1'b0, '0, 1'b0);
            row.phase = 1 + (i * 3) / N_RANDOM;
            row.drain = (i == N_RANDOM / 3) || (i == 2 * N_RANDOM / 3);
            stim_q.push_back(row);
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (next_idx == stim_q.size() && pending_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("bhaskara_trig_approx verification clean");
        else
            $display("bhaskara_trig_approx verification failed");
        $finish;
    end
endmodule
